>>> design/lms_adaptive_fir_filter_top_assert.svh
// Assertion macros for the LMS adaptive FIR filter top level.
// Included by lms_adaptive_fir_filter_top.sv; no other dependencies.
`ifndef LMS_ADAPTIVE_FIR_FILTER_TOP_ASSERT_SVH
`define LMS_ADAPTIVE_FIR_FILTER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define LAFIR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LAFIR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/lafir_pkg.sv
// Shared widths, register indexes, codes and types of the LMS adaptive FIR filter.
// No dependencies; imported by every module of the block.
`default_nettype none

package lafir_pkg;

   localparam int DEFAULT_MAX_TAPS = 32;

   localparam int SAMPLE_W = 16;
   localparam int WEIGHT_W = 32;
   localparam int ERR_W    = 17;
   localparam int STEP_W   = 31;
   localparam int TAPCNT_W = 6;
   localparam int PROD_W   = WEIGHT_W + SAMPLE_W;
   localparam int EV_W     = ERR_W + SAMPLE_W;
   localparam int UPD_W    = 64;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 31;

   localparam logic [CSR_ADDR_W-1:0] CSR_STEP_SIZE = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_TAP_COUNT = 2'd1;

   localparam logic [STEP_W-1:0]   STEP_SIZE_RESET = 31'd65536;
   localparam logic [TAPCNT_W-1:0] TAP_COUNT_RESET = 6'd32;

   localparam logic MODE_TRAIN = 1'b0;
   localparam logic MODE_RUN   = 1'b1;

   // Controls from the sequencer to the shared multiply-accumulate unit.
   typedef struct packed {
      logic issue;
      logic update;
      logic acc_clear;
   } mac_ctl_type;

   function automatic int idx_width(int max_taps);
      return (max_taps > 1) ? $clog2(max_taps) : 1;
   endfunction

   function automatic int cnt_width(int max_taps);
      return $clog2(max_taps + 1);
   endfunction

   function automatic int acc_width(int max_taps);
      return PROD_W + $clog2(max_taps) + 1;
   endfunction

endpackage

`default_nettype wire

>>> design/lafir_delay_line.sv
// Circular sample store of the filter: one write port for the push, one read port.
// Depends on lafir_pkg; a fill count stands in for clearing the memory at reset.
`default_nettype none

module lafir_delay_line #(
   parameter int MAX_TAPS = 32,
   localparam int IDX_W = lafir_pkg::idx_width(MAX_TAPS)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push_en,
   input  logic signed [lafir_pkg::SAMPLE_W-1:0] push_data,
   input  logic                                 rd_en,
   input  logic [IDX_W-1:0]                     rd_tap,
   output logic signed [lafir_pkg::SAMPLE_W-1:0] rd_data
);
   import lafir_pkg::*;

   localparam int CNT_W = cnt_width(MAX_TAPS);

   logic signed [SAMPLE_W-1:0] mem [MAX_TAPS];
   logic [IDX_W-1:0]           wp_ff, wp_in;
   logic [CNT_W-1:0]           fill_ff, fill_in;
   logic [IDX_W-1:0]           newest;
   logic [IDX_W-1:0]           rd_idx;
   logic signed [SAMPLE_W-1:0] q_ff;
   logic                       q_vld_ff;

   always_comb begin
      wp_in   = wp_ff;
      fill_in = fill_ff;
      if (push_en) begin
         wp_in = (wp_ff == IDX_W'(MAX_TAPS - 1)) ? '0 : wp_ff + 1'b1;
         if (fill_ff != CNT_W'(MAX_TAPS)) begin
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   // Tap k sits k places behind the newest sample, wrapping around the store.
   always_comb begin
      newest = (wp_ff == '0) ? IDX_W'(MAX_TAPS - 1) : wp_ff - 1'b1;
      if (newest >= rd_tap) begin
         rd_idx = newest - rd_tap;
      end else begin
         rd_idx = IDX_W'((IDX_W + 1)'(newest) + (IDX_W + 1)'(MAX_TAPS)
                         - (IDX_W + 1)'(rd_tap));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wp_ff   <= wp_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         mem[wp_ff] <= push_data;
      end
      if (rd_en) begin
         q_ff     <= mem[rd_idx];
         q_vld_ff <= (CNT_W'(rd_tap) < fill_ff);
      end
   end

   // Taps older than the samples pushed so far read as zero.
   assign rd_data = q_vld_ff ? q_ff : '0;

endmodule

`default_nettype wire

>>> design/lafir_weight_bank.sv
// Weight store of the filter: one read port and one write port, registered read.
// Depends on lafir_pkg; a high-water mark of trained taps stands in for clearing.
`default_nettype none

module lafir_weight_bank #(
   parameter int MAX_TAPS = 32,
   localparam int IDX_W = lafir_pkg::idx_width(MAX_TAPS),
   localparam int CNT_W = lafir_pkg::cnt_width(MAX_TAPS)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 rd_en,
   input  logic [IDX_W-1:0]                     rd_tap,
   output logic signed [lafir_pkg::WEIGHT_W-1:0] rd_data,
   input  logic                                 wr_en,
   input  logic [IDX_W-1:0]                     wr_tap,
   input  logic signed [lafir_pkg::WEIGHT_W-1:0] wr_data,
   input  logic                                 mark_en,
   input  logic [CNT_W-1:0]                     mark_taps
);
   import lafir_pkg::*;

   logic signed [WEIGHT_W-1:0] mem [MAX_TAPS];
   logic [CNT_W-1:0]           hwm_ff, hwm_in;
   logic signed [WEIGHT_W-1:0] q_ff;
   logic                       q_vld_ff;

   // A training pass writes every tap below its tap count, so entries at or
   // above the highest count ever trained still hold their reset value.
   always_comb begin
      hwm_in = hwm_ff;
      if (mark_en && (mark_taps > hwm_ff)) begin
         hwm_in = mark_taps;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hwm_ff <= '0;
      end else begin
         hwm_ff <= hwm_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_tap] <= wr_data;
      end
      if (rd_en) begin
         q_ff     <= mem[rd_tap];
         q_vld_ff <= (CNT_W'(rd_tap) < hwm_ff);
      end
   end

   assign rd_data = q_vld_ff ? q_ff : '0;

endmodule

`default_nettype wire

>>> design/lafir_mac_unit.sv
// Shared multiply-accumulate pipeline: filter sum and per-tap weight update.
// Depends on lafir_pkg; fed by the weight bank and delay line read ports.
`default_nettype none

module lafir_mac_unit #(
   parameter int MAX_TAPS = 32,
   localparam int IDX_W = lafir_pkg::idx_width(MAX_TAPS),
   localparam int ACC_W = lafir_pkg::acc_width(MAX_TAPS)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  lafir_pkg::mac_ctl_type               ctl,
   input  logic [IDX_W-1:0]                     issue_tap,
   input  logic signed [lafir_pkg::WEIGHT_W-1:0] w_rd_data,
   input  logic signed [lafir_pkg::SAMPLE_W-1:0] v_rd_data,
   input  logic signed [lafir_pkg::ERR_W-1:0]    err,
   input  logic [lafir_pkg::STEP_W-1:0]         step_size,
   output logic signed [ACC_W-1:0]              acc,
   output logic                                 wr_en,
   output logic [IDX_W-1:0]                     wr_tap,
   output logic signed [lafir_pkg::WEIGHT_W-1:0] wr_data,
   output logic                                 busy
);
   import lafir_pkg::*;

   logic                       s1_vld_ff, s2_vld_ff, s3_vld_ff;
   logic [IDX_W-1:0]           s1_tap_ff, s2_tap_ff, s3_tap_ff;
   logic signed [WEIGHT_W-1:0] w2_ff, w3_ff;
   logic signed [WEIGHT_W-1:0] mul_a;
   logic signed [PROD_W-1:0]   prod1, prod1_ff;
   logic signed [EV_W-1:0]     ev;
   logic signed [STEP_W:0]     mu_s;
   logic signed [EV_W+STEP_W:0] prod2;
   logic signed [UPD_W-1:0]    prod2_ff;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [WEIGHT_W:0]   w_sum;

   // Stage 1 multiplier: weight times tap while filtering, error times tap
   // while updating.
   always_comb begin
      if (ctl.update) begin
         mul_a = {{(WEIGHT_W - ERR_W){err[ERR_W-1]}}, err};
      end else begin
         mul_a = w_rd_data;
      end
      prod1 = mul_a * v_rd_data;
   end

   // Stage 2 multiplier: the error-tap product fits 33 bits, scaled by mu.
   always_comb begin
      ev    = prod1_ff[EV_W-1:0];
      mu_s  = {1'b0, step_size};
      prod2 = ev * mu_s;
   end

   always_comb begin
      acc_in = acc_ff;
      if (ctl.acc_clear) begin
         acc_in = '0;
      end else if (s2_vld_ff && !ctl.update) begin
         acc_in = acc_ff + ACC_W'(prod1_ff);
      end
   end

   // Stage 3: add the floored scaled product and saturate to 32 bits.
   always_comb begin
      w_sum = {w3_ff[WEIGHT_W-1], w3_ff} + {prod2_ff[UPD_W-1], prod2_ff[UPD_W-1:32]};
      if (w_sum[WEIGHT_W] != w_sum[WEIGHT_W-1]) begin
         wr_data = w_sum[WEIGHT_W] ? {1'b1, {(WEIGHT_W - 1){1'b0}}}
                                   : {1'b0, {(WEIGHT_W - 1){1'b1}}};
      end else begin
         wr_data = w_sum[WEIGHT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= ctl.issue;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff && ctl.update;
      end
   end

   always_ff @(posedge clock) begin
      s1_tap_ff <= issue_tap;
      s2_tap_ff <= s1_tap_ff;
      s3_tap_ff <= s2_tap_ff;
      w2_ff     <= w_rd_data;
      w3_ff     <= w2_ff;
      prod1_ff  <= prod1;
      prod2_ff  <= prod2[UPD_W-1:0];
      acc_ff    <= acc_in;
   end

   assign acc    = acc_ff;
   assign wr_en  = s3_vld_ff;
   assign wr_tap = s3_tap_ff;
   assign busy   = s1_vld_ff || s2_vld_ff || s3_vld_ff;

endmodule

`default_nettype wire

>>> design/lms_adaptive_fir_filter_top.sv
// LMS adaptive FIR filter top level: sequencer, registers, result register.
// Depends on lafir_pkg, lafir_delay_line, lafir_weight_bank, lafir_mac_unit.
// A train item walks the taps twice through the shared multiply-accumulate unit, a trained
// run item once, and a run item before training not at all. The next item is taken the cycle
// after the result register loads.
// Synchronous reset empties both memories at once through a fill count and a trained-tap mark.
`default_nettype none
`include "lms_adaptive_fir_filter_top_assert.svh"

module lms_adaptive_fir_filter_top #(
   parameter int MAX_TAPS = lafir_pkg::DEFAULT_MAX_TAPS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_mode,
   input  logic signed [lafir_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic signed [lafir_pkg::SAMPLE_W-1:0]  req_desired,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [lafir_pkg::SAMPLE_W-1:0]  rsp_filtered,
   output logic signed [lafir_pkg::ERR_W-1:0]     rsp_error,
   output logic                                   rsp_trained,
   input  logic                                   csr_wr_en,
   input  logic [lafir_pkg::CSR_ADDR_W-1:0]       csr_index,
   input  logic [lafir_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import lafir_pkg::*;

   localparam int IDX_W = idx_width(MAX_TAPS);
   localparam int CNT_W = cnt_width(MAX_TAPS);
   localparam int ACC_W = acc_width(MAX_TAPS);

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_FILT    = 7'b0000010,
      ST_DRAIN_F = 7'b0000100,
      ST_ERR     = 7'b0001000,
      ST_UPD     = 7'b0010000,
      ST_DRAIN_U = 7'b0100000,
      ST_OUT     = 7'b1000000
   } state_type;

   state_type                  state_ff, state_in;
   logic [IDX_W-1:0]           k_ff, k_in;
   logic [CNT_W-1:0]           taps_ff, taps_in;
   logic                       mode_ff, mode_in;
   logic signed [SAMPLE_W-1:0] desired_ff, desired_in;
   logic signed [SAMPLE_W-1:0] y_ff, y_in;
   logic signed [ERR_W-1:0]    e_ff, e_in;
   logic                       trained_ff, trained_in;
   logic [STEP_W-1:0]          step_size_ff, step_size_in;
   logic [TAPCNT_W-1:0]        tap_count_ff, tap_count_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_filtered_ff;
   logic signed [ERR_W-1:0]    rsp_error_ff;
   logic                       rsp_trained_ff;

   logic                       req_xfer;
   logic                       rsp_load;
   logic                       push_en;
   logic                       last_tap;
   logic                       mark_en;
   logic [CNT_W-1:0]           active_taps;
   logic signed [ACC_W-1:0]    acc;
   logic signed [SAMPLE_W-1:0] y_sat;
   mac_ctl_type                mac_ctl;
   logic                       mac_busy;
   logic signed [WEIGHT_W-1:0] w_rd_data;
   logic signed [SAMPLE_W-1:0] v_rd_data;
   logic                       wr_en;
   logic [IDX_W-1:0]           wr_tap;
   logic signed [WEIGHT_W-1:0] wr_data;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign push_en   = req_xfer && ((req_mode == MODE_TRAIN) || trained_ff);
   assign rsp_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);
   assign last_tap  = ((CNT_W'(k_ff) + 1'b1) == taps_ff);
   assign mark_en   = (state_ff == ST_DRAIN_U) && !mac_busy;

   always_comb begin
      if (tap_count_ff == '0) begin
         active_taps = CNT_W'(1);
      end else if (32'(tap_count_ff) > MAX_TAPS) begin
         active_taps = CNT_W'(MAX_TAPS);
      end else begin
         active_taps = CNT_W'(tap_count_ff);
      end
   end

   // Floor by 2^32 is a plain bit select; saturate when the upper bits disagree.
   always_comb begin
      if (!((&acc[ACC_W-1:SAMPLE_W+31]) || !(|acc[ACC_W-1:SAMPLE_W+31]))) begin
         y_sat = acc[ACC_W-1] ? {1'b1, {(SAMPLE_W - 1){1'b0}}}
                              : {1'b0, {(SAMPLE_W - 1){1'b1}}};
      end else begin
         y_sat = acc[SAMPLE_W+31:32];
      end
   end

   always_comb begin
      mac_ctl.issue     = (state_ff == ST_FILT) || (state_ff == ST_UPD);
      mac_ctl.update    = (state_ff == ST_UPD) || (state_ff == ST_DRAIN_U);
      mac_ctl.acc_clear = req_xfer;
   end

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      taps_in      = taps_ff;
      mode_in      = mode_ff;
      desired_in   = desired_ff;
      y_in         = y_ff;
      e_in         = e_ff;
      trained_in   = trained_ff;
      step_size_in = step_size_ff;
      tap_count_in = tap_count_ff;

      if (csr_wr_en) begin
         if (csr_index == CSR_STEP_SIZE) begin
            step_size_in = csr_wdata[STEP_W-1:0];
         end else if (csr_index == CSR_TAP_COUNT) begin
            tap_count_in = csr_wdata[TAPCNT_W-1:0];
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               mode_in    = req_mode;
               desired_in = req_desired;
               taps_in    = active_taps;
               k_in       = '0;
               if (push_en) begin
                  state_in = ST_FILT;
               end else begin
                  // Run before any training: nothing stored, zero result.
                  y_in     = '0;
                  e_in     = '0;
                  state_in = ST_OUT;
               end
            end
         end
         ST_FILT: begin
            k_in = k_ff + 1'b1;
            if (last_tap) begin
               state_in = ST_DRAIN_F;
            end
         end
         ST_DRAIN_F: begin
            if (!mac_busy) begin
               y_in     = y_sat;
               state_in = ST_ERR;
            end
         end
         ST_ERR: begin
            k_in = '0;
            if (mode_ff == MODE_TRAIN) begin
               e_in     = {desired_ff[SAMPLE_W-1], desired_ff} - {y_ff[SAMPLE_W-1], y_ff};
               state_in = ST_UPD;
            end else begin
               e_in     = '0;
               state_in = ST_OUT;
            end
         end
         ST_UPD: begin
            k_in = k_ff + 1'b1;
            if (last_tap) begin
               state_in = ST_DRAIN_U;
            end
         end
         ST_DRAIN_U: begin
            if (!mac_busy) begin
               trained_in = 1'b1;
               state_in   = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         trained_ff   <= 1'b0;
         step_size_ff <= STEP_SIZE_RESET;
         tap_count_ff <= TAP_COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         trained_ff   <= trained_in;
         step_size_ff <= step_size_in;
         tap_count_ff <= tap_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      taps_ff    <= taps_in;
      mode_ff    <= mode_in;
      desired_ff <= desired_in;
      y_ff       <= y_ff == y_in ? y_ff : y_in;
      e_ff       <= e_in;
      if (rsp_load) begin
         rsp_filtered_ff <= y_ff;
         rsp_error_ff    <= e_ff;
         rsp_trained_ff  <= trained_ff;
      end
   end

   lafir_delay_line #(
      .MAX_TAPS (MAX_TAPS)
   ) u_delay_line (
      .clock     (clock),
      .reset     (reset),
      .push_en   (push_en),
      .push_data (req_sample),
      .rd_en     (mac_ctl.issue),
      .rd_tap    (k_ff),
      .rd_data   (v_rd_data)
   );

   lafir_weight_bank #(
      .MAX_TAPS (MAX_TAPS)
   ) u_weight_bank (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (mac_ctl.issue),
      .rd_tap    (k_ff),
      .rd_data   (w_rd_data),
      .wr_en     (wr_en),
      .wr_tap    (wr_tap),
      .wr_data   (wr_data),
      .mark_en   (mark_en),
      .mark_taps (taps_ff)
   );

   lafir_mac_unit #(
      .MAX_TAPS (MAX_TAPS)
   ) u_mac_unit (
      .clock     (clock),
      .reset     (reset),
      .ctl       (mac_ctl),
      .issue_tap (k_ff),
      .w_rd_data (w_rd_data),
      .v_rd_data (v_rd_data),
      .err       (e_ff),
      .step_size (step_size_ff),
      .acc       (acc),
      .wr_en     (wr_en),
      .wr_tap    (wr_tap),
      .wr_data   (wr_data),
      .busy      (mac_busy)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = rsp_filtered_ff;
   assign rsp_error    = rsp_error_ff;
   assign rsp_trained  = rsp_trained_ff;

   `LAFIR_ASSERT_IMP(a_wr_only_in_update, clock, reset, wr_en, (state_ff == ST_UPD || state_ff == ST_DRAIN_U), "weight write outside the update pass")
   `LAFIR_ASSERT_IMP(a_sum_complete, clock, reset, (state_ff == ST_ERR), !mac_busy, "error formed before the filter sum drained")
   `LAFIR_ASSERT_NXT(a_rsp_from_out, clock, reset, (!rsp_valid_ff && state_ff != ST_OUT), !rsp_valid_ff, "result shown without a pass through the output state")
   `LAFIR_ASSERT_IMP(a_untrained_zero, clock, reset, (rsp_valid_ff && !rsp_trained_ff), (rsp_filtered_ff == '0 && rsp_error_ff == '0), "untrained result is not zero")

endmodule

`default_nettype wire

>>> dv/lafir_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the LMS adaptive FIR filter: watches the request, result and
// register ports, predicts every result and compares it. Depends on lafir_pkg.
module lafir_result_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_stall,
   input  logic                                   req_mode,
   input  logic signed [lafir_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic signed [lafir_pkg::SAMPLE_W-1:0]  req_desired,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   input  logic signed [lafir_pkg::SAMPLE_W-1:0]  rsp_filtered,
   input  logic signed [lafir_pkg::ERR_W-1:0]     rsp_error,
   input  logic                                   rsp_trained,
   input  logic                                   csr_wr_en,
   input  logic [lafir_pkg::CSR_ADDR_W-1:0]       csr_index,
   input  logic [lafir_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output int                                     mismatches,
   output int                                     outstanding
);
   import lafir_pkg::*;

   localparam int NTAPS = DEFAULT_MAX_TAPS;
   localparam longint WEIGHT_MAX = (64'sd1 <<< (WEIGHT_W - 1)) - 64'sd1;
   localparam longint WEIGHT_MIN = -(64'sd1 <<< (WEIGHT_W - 1));
   localparam longint OUT_MAX = (64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1;
   localparam longint OUT_MIN = -(64'sd1 <<< (SAMPLE_W - 1));

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] filtered;
      logic signed [ERR_W-1:0]    error;
      logic                       trained;
   } filter_result_type;

   filter_result_type          awaited_results[$];
   longint                     coeffs[NTAPS];
   logic signed [SAMPLE_W-1:0] history[NTAPS];
   int                         head;
   logic                       adapted;
   logic [STEP_W-1:0]          gain;
   logic [TAPCNT_W-1:0]        tap_setting;

   initial begin
      mismatches = 0;
      outstanding = 0;
   end

   function automatic longint saturate(input longint x, input longint lo, input longint hi);
      return (x < lo) ? lo : ((x > hi) ? hi : x);
   endfunction

   // Sample k steps older than the newest one; head is the next slot to be written.
   function automatic longint delayed(input int k);
      longint v;
      v = history[(head + 2 * NTAPS - 1 - k) % NTAPS];
      return v;
   endfunction

   // Advances the filter state by one item and returns the result it produces.
   function automatic filter_result_type next_filter_result(
      input logic mode,
      input logic signed [SAMPLE_W-1:0] smp,
      input logic signed [SAMPLE_W-1:0] dsd
   );
      filter_result_type r;
      longint acc, y, e, mu, upd;
      int n;
      n = (tap_setting == 0) ? 1 : ((tap_setting > NTAPS) ? NTAPS : int'(tap_setting));
      y = 0;
      e = 0;
      mu = gain;
      // A run transfer before any training leaves the delay line untouched.
      if (mode == MODE_TRAIN || adapted) begin
         history[head] = smp;
         head = (head + 1) % NTAPS;
         acc = 0;
         for (int k = 0; k < n; k++) acc += coeffs[k] * delayed(k);
         y = saturate(acc >>> 32, OUT_MIN, OUT_MAX);
      end
      if (mode == MODE_TRAIN) begin
         e = longint'(dsd) - y;
         for (int k = 0; k < n; k++) begin
            upd = (mu * e * delayed(k)) >>> 32;
            coeffs[k] = saturate(coeffs[k] + upd, WEIGHT_MIN, WEIGHT_MAX);
         end
         adapted = 1'b1;
      end
      r.filtered = y[SAMPLE_W-1:0];
      r.error = e[ERR_W-1:0];
      r.trained = adapted;
      return r;
   endfunction

   task automatic flag_mismatch(input string what, input longint got, input longint want);
      $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      filter_result_type want;
      if (reset) begin
         awaited_results.delete();
         for (int i = 0; i < NTAPS; i++) begin
            coeffs[i] = 0;
            history[i] = '0;
         end
         head = 0;
         adapted = 1'b0;
         gain = STEP_SIZE_RESET;
         tap_setting = TAP_COUNT_RESET;
         outstanding <= 0;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_STEP_SIZE)
               gain = csr_wdata[STEP_W-1:0];
            else if (csr_index == CSR_TAP_COUNT)
               tap_setting = csr_wdata[TAPCNT_W-1:0];
         end
         // A result never leaves in the cycle that its request is taken, so check before queuing.
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               flag_mismatch("unexpected result", rsp_filtered, 0);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_filtered !== want.filtered)
                  flag_mismatch("filtered", rsp_filtered, want.filtered);
               if (rsp_error !== want.error)
                  flag_mismatch("error", rsp_error, want.error);
               if (rsp_trained !== want.trained)
                  flag_mismatch("trained", rsp_trained, want.trained);
            end
         end
         if (req_valid && !req_stall)
            awaited_results.push_back(next_filter_result(req_mode, req_sample, req_desired));
         outstanding <= awaited_results.size();
      end
   end

endmodule

>>> dv/tb_lms_adaptive_fir_filter_top.sv
`timescale 1ns / 100ps
// Stimulus top for lms_adaptive_fir_filter_top: clock, reset, items, register writes,
// output stalls and the verdict. Depends on lafir_pkg and lafir_result_checker.
module tb_lms_adaptive_fir_filter_top;
   import lafir_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_LOW  = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_HIGH = 2'd3;
   localparam logic [STEP_W-1:0]     STEP_MAX = '1;
   localparam int SEGMENTS      = 12;
   localparam int SEGMENT_ITEMS = 160;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 80;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_mode = MODE_TRAIN;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic signed [SAMPLE_W-1:0] req_desired = '0;
   logic rsp_stall = 1'b0;
   logic csr_wr_en = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic req_stall;
   logic rsp_valid;
   logic signed [SAMPLE_W-1:0] rsp_filtered;
   logic signed [ERR_W-1:0] rsp_error;
   logic rsp_trained;

   int  mismatches;
   int  outstanding;
   int  send_idle_pct = 36;
   int  recv_idle_pct = 59;
   bit  hold_request = 1'b0;
   int  train_items = 0;
   int  run_items = 0;
   int  settings = 0;

   lms_adaptive_fir_filter_top uut (.*);

   lafir_result_checker checker_i (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Result side: random stalls, or one long hold-off that lets the block back up.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic send_item(input logic m, input logic signed [SAMPLE_W-1:0] s,
                            input logic signed [SAMPLE_W-1:0] d);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= m;
      req_sample <= s;
      req_desired <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (m == MODE_TRAIN) train_items++;
      else run_items++;
   endtask

   // Waits for every awaited result, then lets the block finish any tail work.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [CSR_DATA_W-1:0] v);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
   endtask

   task automatic configure(input logic [STEP_W-1:0] step, input logic [TAPCNT_W-1:0] taps);
      write_reg(CSR_STEP_SIZE, CSR_DATA_W'(step));
      write_reg(CSR_TAP_COUNT, CSR_DATA_W'(taps));
      csr_wr_en <= 1'b0;
      settings++;
   endtask

   // Mix of full-range values, small values and the corners of the range.
   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      logic [31:0] r;
      r = $urandom;
      case (r[31:30])
         2'd0: return {{8{r[7]}}, r[7:0]};
         2'd1: begin
            case (r[29:28])
               2'd0: return 16'sh7FFF;
               2'd1: return 16'sh8000;
               2'd2: return 16'sh0000;
               default: return 16'shFFFF;
            endcase
         end
         default: return r[15:0];
      endcase
   endfunction

   function automatic logic [STEP_W-1:0] random_step();
      case ($urandom_range(5))
         0: return '0;
         1: return STEP_MAX;
         2: return STEP_SIZE_RESET;
         3: return STEP_W'(1) << $urandom_range(30);
         default: return STEP_W'($urandom);
      endcase
   endfunction

   function automatic logic [TAPCNT_W-1:0] random_taps();
      case ($urandom_range(5))
         0: return '0;
         1: return TAPCNT_W'(1);
         2: return TAPCNT_W'(DEFAULT_MAX_TAPS);
         3: return TAPCNT_W'($urandom_range(63, DEFAULT_MAX_TAPS + 1));
         default: return TAPCNT_W'($urandom_range(DEFAULT_MAX_TAPS, 1));
      endcase
   endfunction

   initial begin
      logic signed [SAMPLE_W-1:0] prev, smp, dsd;
      prev = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset settings; run transfers ahead of any training must answer zero.
      send_item(MODE_RUN, 16'sh7FFF, 16'sh7FFF);
      send_item(MODE_RUN, 16'sh8000, 16'sh0000);
      send_item(MODE_TRAIN, 16'sh7FFF, 16'sh8000);
      send_item(MODE_TRAIN, 16'sh8000, 16'sh7FFF);
      send_item(MODE_TRAIN, 16'sh0000, 16'sh0000);
      send_item(MODE_RUN, 16'sh7FFF, 16'sh0000);
      send_item(MODE_RUN, 16'sh8000, 16'sh0000);
      settle();

      // Writes to the unused indexes must leave both registers alone.
      write_reg(CSR_SPARE_LOW, '1);
      write_reg(CSR_SPARE_HIGH, '0);
      // Largest gain with a zero tap count, which behaves as a single tap.
      configure(STEP_MAX, TAPCNT_W'(0));
      send_item(MODE_TRAIN, 16'sh7FFF, 16'sh7FFF);
      send_item(MODE_TRAIN, 16'sh8000, 16'sh8000);
      send_item(MODE_TRAIN, 16'sh7FFF, 16'sh8000);
      send_item(MODE_TRAIN, 16'sh0001, 16'shFFFF);
      send_item(MODE_RUN, 16'shFFFF, 16'sh0000);
      settle();

      // Tap count above the maximum; repeated corner items drive weights into saturation.
      configure(STEP_MAX, TAPCNT_W'(63));
      repeat (4) send_item(MODE_TRAIN, 16'sh7FFF, 16'sh7FFF);
      repeat (2) send_item(MODE_TRAIN, 16'sh8000, 16'sh8000);
      send_item(MODE_RUN, 16'sh7FFF, 16'sh0000);
      send_item(MODE_RUN, 16'sh8000, 16'sh0000);
      settle();

      configure('0, TAPCNT_W'(1));
      send_item(MODE_TRAIN, 16'sh7FFF, 16'sh8000);
      send_item(MODE_RUN, 16'sh0064, 16'sh0000);

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         settle();
         configure(random_step(), random_taps());
         send_idle_pct = (seg < SEGMENTS / 3) ? 36 : ((seg < 2 * SEGMENTS / 3) ? 59 : 0);
         recv_idle_pct = (seg < SEGMENTS / 3) ? 59 : ((seg < 2 * SEGMENTS / 3) ? 36 : 0);
         if (seg == 2) hold_request = 1'b1;
         for (int i = 0; i < SEGMENT_ITEMS; i++) begin
            smp = random_sample();
            // Half the desired values follow the previous sample, as an unknown plant would.
            dsd = $urandom_range(1) ? prev : random_sample();
            send_item(($urandom_range(99) < 65) ? MODE_TRAIN : MODE_RUN, smp, dsd);
            prev = smp;
         end
      end
      settle();

      $display("Covered %0d train and %0d run items over %0d register settings,",
               train_items, run_items, settings);
      $display("with three idle and stall mixes and one long hold-off on the result side.");
      if (mismatches == 0)
         $display("lms_adaptive_fir_filter_top verification clean");
      else
         $display("lms_adaptive_fir_filter_top verification failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("lms_adaptive_fir_filter_top verification failed");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+design
design/lafir_pkg.sv
design/lafir_delay_line.sv
design/lafir_weight_bank.sv
design/lafir_mac_unit.sv
design/lms_adaptive_fir_filter_top.sv
dv/lafir_result_checker.sv
dv/tb_lms_adaptive_fir_filter_top.sv
